FILE: src/tnr_pkg.sv
// Package of the telnet option negotiation responder.
// Holds the shared protocol codes, parser and job types and the default sizes.
// Depends on nothing; every module of the block imports it.
package tnr_pkg;

  localparam int NAME_MAX_CHARS_DEF = 8;
  localparam int JOB_FIFO_DEPTH_DEF = 4;

  // Longest run of output bytes caused by one received byte is 14.
  localparam int RUN_IDX_W = 4;

  localparam logic [7:0] CMD_IAC    = 8'd255;
  localparam logic [7:0] CMD_SE     = 8'd240;
  localparam logic [7:0] CMD_SB     = 8'd250;
  localparam logic [7:0] CMD_OFFER  = 8'd251;
  localparam logic [7:0] CMD_REFUSE = 8'd252;
  localparam logic [7:0] CMD_DO     = 8'd253;
  localparam logic [7:0] CMD_FORBID = 8'd254;

  localparam logic [7:0] OP_BINARY     = 8'd0;
  localparam logic [7:0] OP_ECHO       = 8'd1;
  localparam logic [7:0] OP_NO_GOAHEAD = 8'd3;
  localparam logic [7:0] OP_TTYPE      = 8'd24;

  localparam logic [7:0] TTYPE_IS = 8'd0;

  typedef enum logic {
    CFG_NAME_CHARS = 1'b0,
    CFG_NAME_LEN   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_BOUNDARY,
    PH_AFTER_IAC,
    PH_OPTION,
    PH_SB_OPT,
    PH_SB_BODY,
    PH_SB_BODY_IAC
  } phase_t;

  typedef enum logic [1:0] {
    JOB_DATA,   // one data byte to the terminal
    JOB_PAIR,   // escaped IAC IAC to the terminal
    JOB_REPLY,  // IAC <cmd> <opt> to the server
    JOB_TTYPE   // terminal type subnegotiation reply
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] lead;  // data byte or reply command
    logic [7:0] opt;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } job_req_t;

endpackage

FILE: src/telnet_option_negotiation_responder_core.sv
// Top level of the telnet option negotiation responder.
// Instantiates tnr_front, tnr_job_fifo and tnr_back; depends on tnr_pkg.
//
// Usage:
//   Input channel: one received byte per beat (in_rx_byte, in_segment_end),
//   taken at a clock edge with push high and full low. Result channel: a
//   queue read port; while empty is low the oldest byte sits on out_byte,
//   out_to_terminal and out_run_last, and pop high takes it.
//   Config port: cfg_we writes cfg_wdata into register cfg_index (0 = name
//   characters, 1 = name length); write only while the block is idle.
//   Path: with the emitter free, the job caused by an input beat is written
//   into the job queue as the beat is taken and then loaded into the
//   registered output stage, at which clock edge empty falls.
//   Throughput: one input beat per cycle while each beat yields at most one
//   output byte and pop stays high; the emitter drives one output byte per
//   cycle while pop is high, so a beat that yields a run of up to 14 bytes
//   occupies the emitter to its last byte while the job queue takes beats.
//   Stall: when pop stays low the output stage holds, the emitter stops, the
//   job queue fills and full rises; nothing is lost.
//   Reset (rst_n low, synchronous): parser at a command boundary, data mode
//   off, queue and output stage empty, name registers cleared.
module telnet_option_negotiation_responder_core #(
  parameter int NAME_MAX_CHARS = tnr_pkg::NAME_MAX_CHARS_DEF,
  parameter int JOB_FIFO_DEPTH = tnr_pkg::JOB_FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_segment_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_to_terminal,
  output logic        out_run_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);
  import tnr_pkg::*;

  logic [8*NAME_MAX_CHARS-1:0] name_chars_r;
  logic [3:0]                  name_len_r;

  logic     in_accept;
  job_req_t job_req;
  logic     job_valid;
  job_t     job_head;
  logic     job_pop;

  // Config registers: name characters are kept only up to the stored size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_chars_r <= '0;
      name_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NAME_CHARS: name_chars_r <= cfg_wdata[8*NAME_MAX_CHARS-1:0];
        CFG_NAME_LEN:   name_len_r   <= cfg_wdata[3:0];
        default:        name_len_r   <= name_len_r;
      endcase
    end
  end

  // Take a beat whenever the job queue has room; each beat adds at most one job.
  assign in_accept = push && !full;

  tnr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .rx_byte     (in_rx_byte),
    .segment_end (in_segment_end),
    .req         (job_req)
  );

  tnr_job_fifo #(
    .DEPTH (JOB_FIFO_DEPTH)
  ) u_job_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (job_req),
    .full     (full),
    .rd_pop   (job_pop),
    .rd_valid (job_valid),
    .rd_job   (job_head)
  );

  tnr_back #(
    .NAME_MAX_CHARS (NAME_MAX_CHARS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job             (job_head),
    .job_pop         (job_pop),
    .name_chars      (name_chars_r),
    .name_length     (name_len_r),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_to_terminal (out_to_terminal),
    .out_run_last    (out_run_last)
  );

  // The front never offers a job unless the beat was taken.
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    job_req.push |-> in_accept)
    else $error("job pushed without an accepted beat");

  // A terminal byte that does not end its run is the first half of IAC IAC.
  a_pair_first_half: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_to_terminal && !out_run_last) |-> (out_byte == CMD_IAC))
    else $error("unterminated terminal run is not an escaped IAC");

  // The emitter only pulls from a non-empty queue.
  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("job queue popped while empty");

  // Reset leaves the output side empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("output not empty after reset");

endmodule

FILE: src/tnr_front.sv
// Front parser of the telnet responder: walks the IAC command grammar.
// Turns each received byte into at most one output job for the back end.
// Depends on tnr_pkg.
module tnr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic              segment_end,
  output tnr_pkg::job_req_t req
);
  import tnr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] opt_r, opt_nxt;
  logic       pass_r, pass_nxt;

  logic       common_opt;
  logic [7:0] reply_cmd;
  logic       reply_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BOUNDARY;
      cmd_r   <= '0;
      opt_r   <= '0;
      pass_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      opt_r   <= opt_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // Answer for a completed two-byte negotiation, the option being rx_byte.
  always_comb begin
    common_opt = (rx_byte == OP_NO_GOAHEAD) || (rx_byte == OP_BINARY) ||
                 (rx_byte == OP_TTYPE);
    reply_ok  = 1'b1;
    reply_cmd = CMD_FORBID;
    unique case (cmd_r)
      CMD_DO:     reply_cmd = (common_opt || rx_byte == OP_ECHO) ? CMD_OFFER : CMD_REFUSE;
      CMD_OFFER:  reply_cmd = common_opt ? CMD_DO : CMD_FORBID;
      CMD_FORBID: reply_cmd = CMD_REFUSE;
      CMD_REFUSE: reply_cmd = CMD_FORBID;
      default:    reply_ok  = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    opt_nxt      = opt_r;
    pass_nxt     = pass_r;
    req.push     = 1'b0;
    req.job.kind = JOB_DATA;
    req.job.lead = rx_byte;
    req.job.opt  = rx_byte;
    if (accept) begin
      if (pass_r) begin
        req.push = 1'b1;
      end else begin
        unique case (phase_r)
          PH_BOUNDARY: begin
            if (rx_byte == CMD_IAC) begin
              phase_nxt = PH_AFTER_IAC;
            end else begin
              pass_nxt = 1'b1;
              req.push = 1'b1;
            end
          end
          PH_AFTER_IAC: begin
            if (rx_byte == CMD_IAC) begin
              req.push     = 1'b1;
              req.job.kind = JOB_PAIR;
              pass_nxt     = 1'b1;
              phase_nxt    = PH_BOUNDARY;
            end else begin
              cmd_nxt   = rx_byte;
              phase_nxt = (rx_byte == CMD_SB) ? PH_SB_OPT : PH_OPTION;
            end
          end
          PH_OPTION: begin
            opt_nxt      = rx_byte;
            req.push     = reply_ok;
            req.job.kind = JOB_REPLY;
            req.job.lead = reply_cmd;
            phase_nxt    = PH_BOUNDARY;
          end
          PH_SB_OPT: begin
            opt_nxt   = rx_byte;
            phase_nxt = (rx_byte == CMD_IAC) ? PH_SB_BODY_IAC : PH_SB_BODY;
          end
          PH_SB_BODY: begin
            if (rx_byte == CMD_IAC) begin
              phase_nxt = PH_SB_BODY_IAC;
            end
          end
          PH_SB_BODY_IAC: begin
            if (rx_byte == CMD_SE) begin
              req.push     = (opt_r == OP_TTYPE);
              req.job.kind = JOB_TTYPE;
              phase_nxt    = PH_BOUNDARY;
            end else if (rx_byte != CMD_IAC) begin
              phase_nxt = PH_SB_BODY;
            end
          end
          default: phase_nxt = PH_BOUNDARY;
        endcase
      end
      // Drop any open sequence and leave data mode at the segment's end.
      if (segment_end) begin
        phase_nxt = PH_BOUNDARY;
        pass_nxt  = 1'b0;
      end
    end
  end

endmodule

FILE: src/tnr_job_fifo.sv
// Job queue between the parser front and the byte emitter back end.
// Small register-based FIFO with registered occupancy; depends on tnr_pkg.
module tnr_job_fifo #(
  parameter int DEPTH = tnr_pkg::JOB_FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tnr_pkg::job_req_t wr,
  output logic              full,
  input  logic              rd_pop,
  output logic              rd_valid,
  output tnr_pkg::job_t     rd_job
);
  import tnr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = slots_r[rd_ptr_r];
  assign do_wr    = wr.push && !full;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr.job;
    end
  end

endmodule

FILE: src/tnr_back.sv
// Back end of the telnet responder: expands queued jobs into output bytes.
// One byte per cycle unless pop stalls; registered output; uses tnr_pkg.
module tnr_back #(
  parameter int NAME_MAX_CHARS = tnr_pkg::NAME_MAX_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  input  tnr_pkg::job_t               job,
  output logic                        job_pop,
  input  logic [8*NAME_MAX_CHARS-1:0] name_chars,
  input  logic [3:0]                  name_length,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_byte,
  output logic                        out_to_terminal,
  output logic                        out_run_last
);
  import tnr_pkg::*;

  logic [RUN_IDX_W-1:0]      idx_r, idx_nxt;
  logic                      valid_r, valid_nxt;
  logic [7:0]                byte_r;
  logic                      term_r;
  logic                      last_r;

  logic                      load;
  logic [7:0]                gen_byte;
  logic                      gen_term;
  logic                      gen_last;
  logic [3:0]                name_len;
  logic [RUN_IDX_W-1:0]      name_sel;
  logic [8*NAME_MAX_CHARS-1:0] name_shift;

  // Saturate the programmed length to the stored name size.
  assign name_len   = (name_length > 4'(NAME_MAX_CHARS)) ? 4'(NAME_MAX_CHARS) : name_length;
  assign name_sel   = idx_r - RUN_IDX_W'(4);
  assign name_shift = name_chars >> {name_sel[2:0], 3'b000};

  always_comb begin
    gen_byte = job.lead;
    gen_term = 1'b0;
    gen_last = 1'b1;
    case (job.kind)
      JOB_DATA: begin
        gen_term = 1'b1;
      end
      JOB_PAIR: begin
        gen_byte = CMD_IAC;
        gen_term = 1'b1;
        gen_last = (idx_r == RUN_IDX_W'(1));
      end
      JOB_REPLY: begin
        gen_byte = (idx_r == '0) ? CMD_IAC : (idx_r == RUN_IDX_W'(1)) ? job.lead : job.opt;
        gen_last = (idx_r == RUN_IDX_W'(2));
      end
      JOB_TTYPE: begin
        gen_last = (idx_r == RUN_IDX_W'(5) + name_len);
        if (idx_r == RUN_IDX_W'(0)) begin
          gen_byte = CMD_IAC;
        end else if (idx_r == RUN_IDX_W'(1)) begin
          gen_byte = CMD_SB;
        end else if (idx_r == RUN_IDX_W'(2)) begin
          gen_byte = OP_TTYPE;
        end else if (idx_r == RUN_IDX_W'(3)) begin
          gen_byte = TTYPE_IS;
        end else if (idx_r < RUN_IDX_W'(4) + name_len) begin
          gen_byte = name_shift[7:0];
        end else if (idx_r == RUN_IDX_W'(4) + name_len) begin
          gen_byte = CMD_IAC;
        end else begin
          gen_byte = CMD_SE;
        end
      end
      default: gen_byte = job.lead;
    endcase
  end

  // Advance when the output stage is free or being drained this cycle.
  assign load    = job_valid && (!valid_r || pop);
  assign job_pop = load && gen_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = gen_last ? '0 : idx_r + 1'b1;
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= gen_byte;
      term_r <= gen_term;
      last_r <= gen_last;
    end
  end

  assign empty           = !valid_r;
  assign out_byte        = byte_r;
  assign out_to_terminal = term_r;
  assign out_run_last    = last_r;

endmodule

FILE: test/tb_telnet_option_negotiation_responder_core.sv
`timescale 1ns / 100ps
// Testbench for telnet_option_negotiation_responder_core: it drives received segments
// and checks every reply and data byte against an in-bench predictor of the parser.
// Depends on tnr_pkg and the core RTL only.
module tb_telnet_option_negotiation_responder_core;
  import tnr_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 4;
  // A taken beat passes the job queue and the output stage; leave room for both.
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 10;
  localparam int ITEMS_PER_RUN = 45;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       seg_end;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       to_term;
    logic       last;
  } out_beat_t;

  // DUT ports; every input starts at a known value.
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [7:0]  in_rx_byte     = 8'd0;
  logic        in_segment_end = 1'b0;
  logic        empty;
  logic        pop            = 1'b0;
  logic [7:0]  out_byte;
  logic        out_to_terminal;
  logic        out_run_last;
  logic        cfg_we         = 1'b0;
  cfg_reg_t    cfg_index      = CFG_NAME_CHARS;
  logic [63:0] cfg_wdata      = '0;

  // Stimulus: stash is built by the sequence generator, rx_pending feeds the driver.
  rx_beat_t  stash[$];
  rx_beat_t  rx_pending[$];
  logic [7:0] seg_bytes[$];
  // Bytes the block owes us, oldest first.
  out_beat_t reply_bytes_due[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int beats_sent      = 0;
  int beats_checked   = 0;
  int ttype_replies   = 0;
  int mismatches      = 0;

  // Predictor state: parser position, held command and option, data mode, name registers.
  phase_t      parse_ph     = PH_BOUNDARY;
  logic [7:0]  held_cmd     = 8'd0;
  logic [7:0]  held_opt     = 8'd0;
  logic        in_data_mode = 1'b0;
  logic [63:0] name_chars   = '0;
  logic [3:0]  name_len     = '0;

  out_beat_t want;

  telnet_option_negotiation_responder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_rx_byte      (in_rx_byte),
    .in_segment_end  (in_segment_end),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_to_terminal (out_to_terminal),
    .out_run_last    (out_run_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void put_byte(input logic [7:0] b, input logic to_term);
    out_beat_t ob;
    ob.data    = b;
    ob.to_term = to_term;
    ob.last    = 1'b0;
    reply_bytes_due.push_back(ob);
  endfunction

  function automatic void put_triple(input logic [7:0] verb, input logic [7:0] opt);
    put_byte(CMD_IAC, 1'b0);
    put_byte(verb, 1'b0);
    put_byte(opt, 1'b0);
  endfunction

  // Answer a completed verb/option pair. ECHO is something we do, never ask for.
  function automatic void answer_negotiation();
    logic common;
    common = (held_opt == OP_NO_GOAHEAD) || (held_opt == OP_BINARY) ||
             (held_opt == OP_TTYPE);
    case (held_cmd)
      CMD_DO:     put_triple((common || held_opt == OP_ECHO) ? CMD_OFFER : CMD_REFUSE,
                             held_opt);
      CMD_OFFER:  put_triple(common ? CMD_DO : CMD_FORBID, held_opt);
      CMD_FORBID: put_triple(CMD_REFUSE, held_opt);
      CMD_REFUSE: put_triple(CMD_FORBID, held_opt);
      default: ;
    endcase
  endfunction

  // IAC SB TERMINAL-TYPE IS <name> IAC SE; length saturates at eight, bytes go unescaped.
  function automatic void answer_term_type();
    int n;
    n = (name_len > 4'd8) ? 8 : int'(name_len);
    put_byte(CMD_IAC, 1'b0);
    put_byte(CMD_SB, 1'b0);
    put_byte(OP_TTYPE, 1'b0);
    put_byte(TTYPE_IS, 1'b0);
    for (int i = 0; i < n; i++) put_byte(name_chars[8*i +: 8], 1'b0);
    put_byte(CMD_IAC, 1'b0);
    put_byte(CMD_SE, 1'b0);
    ttype_replies++;
  endfunction

  // Advance the parser by one received byte and queue the bytes it causes.
  function automatic void respond_to_byte(input rx_beat_t bt);
    int        start;
    logic [7:0] b;
    out_beat_t tail;
    start = reply_bytes_due.size();
    b     = bt.rx_byte;
    if (in_data_mode) begin
      put_byte(b, 1'b1);
    end else begin
      case (parse_ph)
        PH_BOUNDARY: begin
          if (b == CMD_IAC) begin
            parse_ph = PH_AFTER_IAC;
          end else begin
            in_data_mode = 1'b1;
            put_byte(b, 1'b1);
          end
        end
        PH_AFTER_IAC: begin
          if (b == CMD_IAC) begin
            // Escaped IAC at a boundary: pass the pair on and switch to data.
            put_byte(CMD_IAC, 1'b1);
            put_byte(CMD_IAC, 1'b1);
            in_data_mode = 1'b1;
            parse_ph     = PH_BOUNDARY;
          end else begin
            held_cmd = b;
            parse_ph = (b == CMD_SB) ? PH_SB_OPT : PH_OPTION;
          end
        end
        PH_OPTION: begin
          held_opt = b;
          answer_negotiation();
          parse_ph = PH_BOUNDARY;
        end
        PH_SB_OPT: begin
          // The option byte may itself be the IAC of the end mark.
          held_opt = b;
          parse_ph = (b == CMD_IAC) ? PH_SB_BODY_IAC : PH_SB_BODY;
        end
        PH_SB_BODY: begin
          if (b == CMD_IAC) parse_ph = PH_SB_BODY_IAC;
        end
        PH_SB_BODY_IAC: begin
          if (b == CMD_SE) begin
            if (held_opt == OP_TTYPE) answer_term_type();
            parse_ph = PH_BOUNDARY;
          end else if (b != CMD_IAC) begin
            parse_ph = PH_SB_BODY;
          end
        end
        default: parse_ph = PH_BOUNDARY;
      endcase
    end
    // Segment end drops any open sequence and leaves data mode.
    if (bt.seg_end) begin
      parse_ph     = PH_BOUNDARY;
      in_data_mode = 1'b0;
    end
    if (reply_bytes_due.size() > start) begin
      tail      = reply_bytes_due.pop_back();
      tail.last = 1'b1;
      reply_bytes_due.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the head of rx_pending, predict on each accepted beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        respond_to_byte(rx_pending.pop_front());
        beats_sent++;
      end
      // Hold push high across back-to-back beats; drop it only to idle or when dry.
      if (rx_pending.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        push           <= 1'b1;
        in_rx_byte     <= rx_pending[0].rx_byte;
        in_segment_end <= rx_pending[0].seg_end;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check every popped byte against the oldest byte due.
  // ---------------------------------------------------------------------------
  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        beats_checked++;
        if (reply_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h term %b last %b",
                                    out_byte, out_to_terminal, out_run_last));
        end else begin
          want = reply_bytes_due.pop_front();
          if (out_byte !== want.data || out_to_terminal !== want.to_term ||
              out_run_last !== want.last)
            report_mismatch($sformatf(
              "out beat %0d: expected byte %02h term %b last %b, got %02h term %b last %b",
              beats_checked, want.data, want.to_term, want.last,
              out_byte, out_to_terminal, out_run_last));
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic add_beat(input logic [7:0] b, input logic e);
    rx_beat_t bt;
    bt.rx_byte = b;
    bt.seg_end = e;
    stash.push_back(bt);
  endtask

  // Move the first cut bytes of seg_bytes to the stash, marking the last as segment end.
  task automatic flush_segment(input int cut);
    for (int i = 0; i < cut; i++) add_beat(seg_bytes[i], i == cut - 1);
    seg_bytes.delete();
  endtask

  function automatic logic [7:0] pick_verb();
    case ($urandom_range(0, 3))
      0:       return CMD_DO;
      1:       return CMD_OFFER;
      2:       return CMD_FORBID;
      default: return CMD_REFUSE;
    endcase
  endfunction

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 7))
      0:       return OP_BINARY;
      1:       return OP_ECHO;
      2:       return OP_NO_GOAHEAD;
      3:       return OP_TTYPE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Subnegotiation body plus end mark: plain bytes, escaped IACs, stray IAC-x pairs.
  task automatic add_sb_body();
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0: begin
          seg_bytes.push_back(CMD_IAC);
          seg_bytes.push_back(CMD_IAC);
        end
        1: begin
          seg_bytes.push_back(CMD_IAC);
          seg_bytes.push_back(8'($urandom_range(0, 239)));
        end
        default: seg_bytes.push_back(8'($urandom_range(0, 254)));
      endcase
    end
    seg_bytes.push_back(CMD_IAC);
    seg_bytes.push_back(CMD_SE);
  endtask

  // One segment: mostly well-formed command runs with random content, some noise,
  // some cut short before the sequence completes.
  task automatic gen_segment();
    int cut;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 8))
        add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      seg_bytes.push_back(CMD_IAC);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          seg_bytes.push_back(pick_verb());
          seg_bytes.push_back(pick_option());
        end
        5, 6: begin
          seg_bytes.push_back(CMD_SB);
          seg_bytes.push_back(OP_TTYPE);
          add_sb_body();
        end
        7: begin
          seg_bytes.push_back(CMD_SB);
          seg_bytes.push_back(8'($urandom_range(0, 255)));
          add_sb_body();
        end
        default: begin
          // A command that takes an option but gets no answer.
          seg_bytes.push_back(8'($urandom_range(0, 249)));
          seg_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    // Optional data tail: a plain byte or an escaped IAC opens pass-through.
    if ($urandom_range(0, 99) < 30) begin
      if ($urandom_range(0, 1) == 0) begin
        seg_bytes.push_back(8'($urandom_range(0, 254)));
      end else begin
        seg_bytes.push_back(CMD_IAC);
        seg_bytes.push_back(CMD_IAC);
      end
      repeat ($urandom_range(0, 4)) seg_bytes.push_back(8'($urandom_range(0, 255)));
    end
    cut = seg_bytes.size();
    if ($urandom_range(0, 99) < 15) cut = $urandom_range(1, seg_bytes.size());
    flush_segment(cut);
  endtask

  task automatic gen_random(input int n);
    int target;
    target = stash.size() + n;
    while (stash.size() < target) gen_segment();
  endtask

  task automatic load_directed();
    // DO ECHO accepted, unknown WILL refused, DONT and WONT mirrored,
    // terminal-type request with empty body, and an SB whose option byte is
    // the IAC of its own end mark.
    seg_bytes = '{CMD_IAC, CMD_DO, OP_ECHO,
                  CMD_IAC, CMD_OFFER, 8'h2a,
                  CMD_IAC, CMD_FORBID, OP_TTYPE,
                  CMD_IAC, CMD_REFUSE, OP_BINARY,
                  CMD_IAC, CMD_SB, OP_TTYPE, CMD_IAC, CMD_SE,
                  CMD_IAC, CMD_SB, CMD_IAC, CMD_SE};
    flush_segment(seg_bytes.size());
    // DO cut short by the end of the segment: no reply.
    seg_bytes = '{CMD_IAC, CMD_DO};
    flush_segment(seg_bytes.size());
    // Escaped IAC at a boundary, then data.
    seg_bytes = '{CMD_IAC, CMD_IAC, 8'h80};
    flush_segment(seg_bytes.size());
    // Plain data at both byte extremes.
    seg_bytes = '{8'h00, 8'hff};
    flush_segment(seg_bytes.size());
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_NAME_CHARS) name_chars = val;
    else name_len = val[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every beat is taken and every due byte has come, then let
  // silent beats still in the pipe drain out.
  task automatic wait_quiet();
    while (rx_pending.size() > 0 || reply_bytes_due.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Feed the stash to the driver under the given idling; optionally stop halfway
  // (often mid-segment) until the block has answered everything.
  task automatic run_phase(input int idle_pct, input int stall_pct, input bit pause_midway);
    int first_part;
    @(negedge clk);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    first_part = pause_midway ? stash.size() / 2 : stash.size();
    repeat (first_part) rx_pending.push_back(stash.pop_front());
    if (pause_midway) begin
      wait_quiet();
      while (stash.size() > 0) rx_pending.push_back(stash.pop_front());
    end
    wait_quiet();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass, name "vt100", no idling.
    write_reg(CFG_NAME_CHARS, 64'h0000_0030_3031_7476);
    write_reg(CFG_NAME_LEN, 64'd5);
    load_directed();
    run_phase(0, 0, 1'b0);

    // Full-length name of all-ones bytes (unescaped IACs in the reply), sender idling.
    write_reg(CFG_NAME_CHARS, {64{1'b1}});
    write_reg(CFG_NAME_LEN, 64'd8);
    gen_random(ITEMS_PER_RUN);
    run_phase(57, 0, 1'b0);

    // Empty name, receiver stalling, sender pauses halfway until all bytes are in.
    write_reg(CFG_NAME_CHARS, {$urandom, $urandom});
    write_reg(CFG_NAME_LEN, 64'd0);
    gen_random(ITEMS_PER_RUN);
    run_phase(0, 57, 1'b1);

    // Length beyond eight saturates; both sides idle.
    write_reg(CFG_NAME_CHARS, {$urandom, $urandom});
    write_reg(CFG_NAME_LEN, 64'd15);
    gen_random(ITEMS_PER_RUN);
    run_phase(36, 36, 1'b0);

    // All-zero name bytes, back to full rate.
    write_reg(CFG_NAME_CHARS, 64'd0);
    write_reg(CFG_NAME_LEN, 64'd3);
    gen_random(ITEMS_PER_RUN);
    run_phase(0, 0, 1'b0);

    $display("Run covered %0d received bytes and %0d output bytes, %0d terminal-type replies,",
             beats_sent, beats_checked, ttype_replies);
    $display("name lengths 0, 3, 5, 8 and 15 under four idling mixes; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(2_000_000);
    $display("Timeout with %0d bytes still due", reply_bytes_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
